### rtl/jst_pkg.sv
// Shared types and constants for the JSON structure tokenizer.
// Used by jst_front, jst_queue, jst_back and json_structure_tokenizer_core.
`timescale 1ns / 1ps

package jst_pkg;

    localparam int MAX_TOKENS  = 256;
    localparam int STACK_DEPTH = 32;
    localparam int MAX_LINE    = 65535;

    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W     = $clog2(STACK_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TDATA_W     = 72;

    // scan modes
    typedef enum logic [1:0] {
        MODE_GAP  = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_PRIM = 2'd3
    } mode_t;

    // record kinds
    localparam logic [2:0] KIND_OBJECT = 3'd0;
    localparam logic [2:0] KIND_ARRAY  = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_PRIM   = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    // status codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LIMIT    = 3'd1;
    localparam logic [2:0] ERR_MISMATCH = 3'd2;
    localparam logic [2:0] ERR_DEEP     = 3'd3;
    localparam logic [2:0] ERR_LONG     = 3'd4;

    // characters
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    // one open container
    typedef struct packed {
        logic [7:0]  number;
        logic        is_array;
        logic [15:0] start;
        logic [7:0]  children;
    } frame_t;

    // every result caused by one input byte
    typedef struct packed {
        logic        leaf_v;
        logic        leaf_prim;
        logic [7:0]  leaf_num;
        logic [15:0] leaf_start;
        logic [16:0] leaf_end;
        logic        close_v;
        frame_t      close_frame;
        logic [16:0] close_end;
        logic        stat_v;
        logic [2:0]  stat_code;
        logic [8:0]  stat_total;
        logic [5:0]  stat_left;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### rtl/json_structure_tokenizer_core.sv
// JSON structure tokenizer, top level.
// Connects jst_front, jst_queue and jst_back; depends on jst_pkg.
//
// Usage:
//   s_ channel carries one byte of a JSON line per transfer; s_tlast marks the
//   last byte of the line. m_ channel carries token and status records, one
//   per transfer, m_tlast on the last record caused by one input byte.
//   cfg_ channel writes token_limit (reset value 256); write it only when idle.
// Path: a record for a transferred byte is written into the result queue, then
//   loaded into the output register that drives m_.
// Throughput: one byte per cycle while the result queue has room. Records leave
//   one per cycle while m_tready is high, so a byte that causes up to 3 records
//   (primitive, closed container, status) holds the output while they go out;
//   the four-bundle queue absorbs such bursts while bytes keep coming.
// Reset clears all line state and the queue; token_limit returns to 256. No
//   memory clearing pass is needed. When m_tready is low the output record
//   holds, the queue fills and s_tready drops once it is full.
`timescale 1ns / 1ps

module json_structure_tokenizer_core import jst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // end_of_line
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] token_number, [23:8] start_pos, [40:24] end_pos, [48:41] child_count,
    // [51:49] status, [60:52] token_total, [66:61] open_left, [71:67] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] kind
    output logic               m_tlast,   // last_of_run
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data   // token_limit
);

    q_wr_t   q_wr;
    q_stat_t q_stat;
    bundle_t head;
    logic    pop;
    logic    accept;

    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    jst_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_line (s_tlast),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .q_wr        (q_wr)
    );

    jst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    jst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/jst_front.sv
// Front end: takes bytes, tracks scan mode, counters and the container stack,
// and builds a bundle per byte, queued if it holds a record. Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_front import jst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        end_of_line,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,
    output q_wr_t       q_wr
);

    logic [8:0]         limit_reg;
    logic [16:0]        pos_reg,    pos_next;
    logic [8:0]         tokens_reg, tokens_next;
    mode_t              mode_reg,   mode_next;
    logic [15:0]        pend_reg,   pend_next;
    logic [DEPTH_W-1:0] depth_reg,  depth_next;
    logic [2:0]         err_reg,    err_next;
    frame_t             top_reg,    top_next;
    frame_t             under_reg;
    frame_t             stack_mem [STACK_DEPTH];

    logic [8:0]         limit_eff;
    logic               tok_ok, is_ws, is_prim_end, too_long, work, gap;
    logic               leaf_req, leaf_prim, leaf_take, push, pop, bump;
    logic [16:0]        leaf_end;
    frame_t             top_b;
    logic [SADDR_W-1:0] wr_addr, rd_addr;
    logic               clear;

    assign clear   = accept && end_of_line;
    assign wr_addr = depth_reg[SADDR_W-1:0] - SADDR_W'(1);
    assign rd_addr = depth_reg[SADDR_W-1:0] - SADDR_W'(3);

    always_comb begin
        limit_eff   = (limit_reg > 9'(MAX_TOKENS)) ? 9'(MAX_TOKENS) : limit_reg;
        tok_ok      = tokens_reg < limit_eff;
        is_ws       = (in_byte == CH_TAB) || (in_byte == CH_CR) ||
                      (in_byte == CH_LF) || (in_byte == CH_SPACE);
        is_prim_end = is_ws || (in_byte == CH_COMMA) ||
                      (in_byte == CH_RBRACKET) || (in_byte == CH_RBRACE);
        too_long    = pos_reg > 17'(MAX_LINE);
        work        = accept && (err_reg == ERR_NONE) && !too_long;

        leaf_req  = 1'b0;
        leaf_prim = 1'b0;
        leaf_end  = pos_reg + 17'd1;
        gap       = 1'b0;
        mode_next = mode_reg;
        pend_next = pend_reg;
        err_next  = err_reg;
        push      = 1'b0;
        pop       = 1'b0;

        if (accept && (err_reg == ERR_NONE) && too_long) begin
            err_next = ERR_LONG;
        end

        if (work) begin
            unique case (mode_reg)
                MODE_STR: begin
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_GAP;
                        leaf_req  = 1'b1;
                    end else if (in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_STR;
                end
                MODE_PRIM: begin
                    if (is_prim_end) begin
                        mode_next = MODE_GAP;
                        leaf_req  = 1'b1;
                        leaf_prim = 1'b1;
                        leaf_end  = pos_reg;
                        // the delimiter is handled only if the primitive got a token
                        gap       = tok_ok;
                    end else if (end_of_line) begin
                        leaf_req  = 1'b1;
                        leaf_prim = 1'b1;
                    end
                end
                MODE_GAP: begin
                    gap = 1'b1;
                end
                default: ;
            endcase
        end

        leaf_take = leaf_req && tok_ok;
        if (leaf_req && !tok_ok) begin
            err_next = ERR_LIMIT;
        end

        if (gap) begin
            if ((in_byte == CH_LBRACE) || (in_byte == CH_LBRACKET)) begin
                if (!tok_ok) begin
                    err_next = ERR_LIMIT;
                end else if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                    err_next = ERR_DEEP;
                end else begin
                    push = 1'b1;
                end
            end else if ((in_byte == CH_RBRACE) || (in_byte == CH_RBRACKET)) begin
                // close with nothing open is ignored
                if (depth_reg != '0) begin
                    if (top_reg.is_array != (in_byte == CH_RBRACKET)) begin
                        err_next = ERR_MISMATCH;
                    end else begin
                        pop = 1'b1;
                    end
                end
            end else if (in_byte == CH_QUOTE) begin
                mode_next = MODE_STR;
                pend_next = pos_reg[15:0];
            end else if (!(is_ws || (in_byte == CH_COLON) || (in_byte == CH_COMMA))) begin
                mode_next = MODE_PRIM;
                pend_next = pos_reg[15:0];
            end
        end

        bump  = (leaf_take || push) && (depth_reg != '0);
        top_b = top_reg;
        if (bump && (top_reg.children != 8'hFF)) begin
            top_b.children = top_reg.children + 8'd1;
        end

        tokens_next = tokens_reg + {8'd0, (leaf_take || push)};
        if (push) begin
            depth_next = depth_reg + DEPTH_W'(1);
            top_next   = '{number: tokens_reg[7:0], is_array: (in_byte == CH_LBRACKET),
                           start: pos_reg[15:0], children: 8'd0};
        end else if (pop) begin
            depth_next = depth_reg - DEPTH_W'(1);
            top_next   = under_reg;
        end else begin
            depth_next = depth_reg;
            top_next   = top_b;
        end

        pos_next = (accept && !too_long) ? pos_reg + 17'd1 : pos_reg;

        q_wr.valid            = accept && (leaf_take || pop || end_of_line);
        q_wr.data.leaf_v      = leaf_take;
        q_wr.data.leaf_prim   = leaf_prim;
        q_wr.data.leaf_num    = tokens_reg[7:0];
        q_wr.data.leaf_start  = pend_reg;
        q_wr.data.leaf_end    = leaf_end;
        q_wr.data.close_v     = pop;
        q_wr.data.close_frame = top_b;
        q_wr.data.close_end   = pos_reg + 17'd1;
        q_wr.data.stat_v      = end_of_line;
        q_wr.data.stat_code   = err_next;
        q_wr.data.stat_total  = tokens_next;
        q_wr.data.stat_left   = 6'(depth_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= 9'(MAX_TOKENS);
            pos_reg    <= '0;
            tokens_reg <= '0;
            mode_reg   <= MODE_GAP;
            pend_reg   <= '0;
            depth_reg  <= '0;
            err_reg    <= ERR_NONE;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
            if (clear) begin
                pos_reg    <= '0;
                tokens_reg <= '0;
                mode_reg   <= MODE_GAP;
                pend_reg   <= '0;
                depth_reg  <= '0;
                err_reg    <= ERR_NONE;
            end else begin
                pos_reg    <= pos_next;
                tokens_reg <= tokens_next;
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                depth_reg  <= depth_next;
                err_reg    <= err_next;
            end
        end
    end

    // top of stack and the entry below it live in registers; the rest in memory
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (pop) begin
            under_reg <= stack_mem[rd_addr];
        end else if (push) begin
            under_reg <= top_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && (depth_reg != '0)) begin
            stack_mem[wr_addr] <= top_b;
        end
    end

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_tokens_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tokens_reg <= 9'(MAX_TOKENS))
        else $error("token count beyond limit");

    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (depth_reg == '0) && (tokens_reg == '0) && (err_reg == ERR_NONE))
        else $error("line state not cleared after last byte");

    a_sticky_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE) && !clear |=> $stable(tokens_reg) && $stable(depth_reg))
        else $error("counts moved after an error");

endmodule

### rtl/jst_queue.sv
// Small bundle FIFO between the front end and the output serializer.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_queue import jst_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_wr_t   q_wr,
    input  logic    pop,
    output bundle_t head,
    output q_stat_t q_stat
);

    bundle_t            entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg,  count_next;

    assign head         = entries[rd_ptr_reg];
    assign q_stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_comb begin
        count_next = count_reg;
        if (q_wr.valid && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !q_wr.valid) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_wr.valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.valid) begin
            entries[wr_ptr_reg] <= q_wr.data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_wr.valid && q_stat.full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_stat.empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/jst_back.sv
// Back end: walks the records of the head bundle and drives the output register.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_back import jst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  bundle_t            head,
    input  q_stat_t            q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    logic [2:0]         done_reg, done_next;
    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic [2:0]         out_kind_reg;
    logic               out_last_reg;

    logic [2:0]         avail, remain, pick;
    logic               load, is_last;
    logic [2:0]         r_kind;
    logic [7:0]         r_num, r_kids;
    logic [15:0]        r_start;
    logic [16:0]        r_end;
    logic [2:0]         r_status;
    logic [8:0]         r_total;
    logic [5:0]         r_left;

    always_comb begin
        avail   = q_stat.empty ? 3'b000 : {head.stat_v, head.close_v, head.leaf_v};
        remain  = avail & ~done_reg;
        // records go out leaf first, then close, then status
        pick    = remain & (~remain + 3'd1);
        is_last = (remain & ~pick) == 3'b000;
        load    = (remain != 3'b000) && (!out_valid_reg || m_tready);
        pop     = load && is_last;

        done_next = done_reg;
        if (load) begin
            done_next = is_last ? 3'b000 : (done_reg | pick);
        end

        r_kind   = KIND_STATUS;
        r_num    = '0;
        r_start  = '0;
        r_end    = '0;
        r_kids   = '0;
        r_status = '0;
        r_total  = '0;
        r_left   = '0;
        if (pick[0]) begin
            r_kind  = head.leaf_prim ? KIND_PRIM : KIND_STRING;
            r_num   = head.leaf_num;
            r_start = head.leaf_start;
            r_end   = head.leaf_end;
        end else if (pick[1]) begin
            r_kind  = head.close_frame.is_array ? KIND_ARRAY : KIND_OBJECT;
            r_num   = head.close_frame.number;
            r_start = head.close_frame.start;
            r_end   = head.close_end;
            r_kids  = head.close_frame.children;
        end else begin
            r_status = head.stat_code;
            r_total  = head.stat_total;
            r_left   = head.stat_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= {5'd0, r_left, r_total, r_status, r_kids, r_end, r_start, r_num};
            out_kind_reg <= r_kind;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### test/json_structure_tokenizer_checker.sv
// Checker for json_structure_tokenizer_core: watches the s_, m_ and cfg_ channels,
// predicts token and status records per accepted byte and compares them in order.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module json_structure_tokenizer_checker import jst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [2:0]         m_tuser,
    input  logic               m_tlast,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [8:0]         cfg_data,
    output int                 fail_count,
    output int                 tokens_pending,
    output int                 records_checked
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  num;
        logic [15:0] start_pos;
        logic [16:0] end_pos;
        logic [7:0]  kids;
        logic [2:0]  code;
        logic [8:0]  total;
        logic [5:0]  left;
        logic        last;
    } token_rec_t;

    // predicted tokenizer state
    logic [8:0]  limit_q;
    logic [16:0] byte_pos;
    logic [8:0]  made;
    mode_t       mode;
    logic [15:0] pend_start;
    logic [5:0]  depth;
    frame_t      open_frames [STACK_DEPTH];
    logic [2:0]  err;

    token_rec_t  step_recs[$];
    token_rec_t  pending_tokens[$];

    function automatic bit is_space(logic [7:0] c);
        return c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE;
    endfunction

    function automatic void clear_line();
        byte_pos   = '0;
        made       = '0;
        mode       = MODE_GAP;
        pend_start = '0;
        depth      = '0;
        err        = ERR_NONE;
    endfunction

    task automatic report(string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH @%0t record %0d: %s", $time, records_checked, msg);
    endtask

    task automatic cmp_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic emit(logic [2:0] kind, logic [7:0] num, logic [15:0] start_pos,
                        logic [16:0] end_pos, logic [7:0] kids, logic [2:0] code,
                        logic [8:0] total, logic [5:0] left);
        token_rec_t r;
        r = '{kind, num, start_pos, end_pos, kids, code, total, left, 1'b0};
        step_recs.push_back(r);
    endtask

    // limit above MAX_TOKENS acts as MAX_TOKENS; 0 fails the first token
    function automatic bit grab_token(output logic [7:0] num);
        logic [8:0] cap;
        cap = (limit_q > MAX_TOKENS) ? 9'(MAX_TOKENS) : limit_q;
        num = made[7:0];
        if (made >= cap) begin
            err = ERR_LIMIT;
            return 1'b0;
        end
        made = made + 9'd1;
        return 1'b1;
    endfunction

    function automatic void bump_parent();
        if (depth != 0 && open_frames[depth - 1].children != 8'hFF)
            open_frames[depth - 1].children = open_frames[depth - 1].children + 8'd1;
    endfunction

    task automatic add_leaf(logic [2:0] kind, logic [15:0] start_pos, logic [16:0] end_pos);
        logic [7:0] num;
        if (grab_token(num)) begin
            bump_parent();
            emit(kind, num, start_pos, end_pos, 8'd0, ERR_NONE, 9'd0, 6'd0);
        end
    endtask

    task automatic scan_gap(logic [7:0] c, logic [16:0] pos);
        logic [7:0] num;
        frame_t     inner;
        if (c == CH_LBRACE || c == CH_LBRACKET) begin
            if (grab_token(num)) begin
                if (depth >= STACK_DEPTH) begin
                    // too deep: the token is given back
                    made = made - 9'd1;
                    err  = ERR_DEEP;
                end else begin
                    bump_parent();
                    open_frames[depth] = '{num, c == CH_LBRACKET, pos[15:0], 8'd0};
                    depth = depth + 6'd1;
                end
            end
        end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
            // a close with nothing open is dropped
            if (depth != 0) begin
                inner = open_frames[depth - 1];
                if (inner.is_array != (c == CH_RBRACKET)) begin
                    err = ERR_MISMATCH;
                end else begin
                    depth = depth - 6'd1;
                    emit(inner.is_array ? KIND_ARRAY : KIND_OBJECT, inner.number, inner.start,
                         pos + 17'd1, inner.children, ERR_NONE, 9'd0, 6'd0);
                end
            end
        end else if (c == CH_QUOTE) begin
            mode       = MODE_STR;
            pend_start = pos[15:0];
        end else if (!(is_space(c) || c == CH_COLON || c == CH_COMMA)) begin
            mode       = MODE_PRIM;
            pend_start = pos[15:0];
        end
    endtask

    task automatic tokenize_byte(logic [7:0] c, logic eol);
        logic [16:0] pos;
        pos = byte_pos;
        step_recs.delete();
        if (err == ERR_NONE && pos > MAX_LINE) begin
            err = ERR_LONG;
        end else if (err == ERR_NONE) begin
            case (mode)
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        mode = MODE_GAP;
                        add_leaf(KIND_STRING, pend_start, pos + 17'd1);
                    end else if (c == CH_BSLASH) begin
                        mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    mode = MODE_STR;
                end
                MODE_PRIM: begin
                    if (is_space(c) || c == CH_COMMA || c == CH_RBRACKET || c == CH_RBRACE) begin
                        mode = MODE_GAP;
                        add_leaf(KIND_PRIM, pend_start, pos);
                        if (err == ERR_NONE)
                            scan_gap(c, pos);
                    end else if (eol) begin
                        // primitive still open at the last byte ends just past it
                        add_leaf(KIND_PRIM, pend_start, pos + 17'd1);
                    end
                end
                default: begin
                    scan_gap(c, pos);
                end
            endcase
        end
        if (pos <= MAX_LINE)
            byte_pos = pos + 17'd1;
        if (eol) begin
            emit(KIND_STATUS, 8'd0, 16'd0, 17'd0, 8'd0, err, made, depth);
            clear_line();
        end
        if (step_recs.size() != 0)
            step_recs[step_recs.size() - 1].last = 1'b1;
        foreach (step_recs[i])
            pending_tokens.push_back(step_recs[i]);
    endtask

    task automatic check_record();
        token_rec_t got;
        token_rec_t want;
        got = '{m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[40:24], m_tdata[48:41],
                m_tdata[51:49], m_tdata[60:52], m_tdata[66:61], m_tlast};
        records_checked++;
        if (m_tdata[71:67] != '0)
            report("nonzero pad bits in tdata");
        if (pending_tokens.size() == 0) begin
            report("record with nothing expected");
            return;
        end
        want = pending_tokens.pop_front();
        cmp_field("kind", got.kind, want.kind);
        cmp_field("token_number", got.num, want.num);
        cmp_field("start_pos", got.start_pos, want.start_pos);
        cmp_field("end_pos", got.end_pos, want.end_pos);
        cmp_field("child_count", got.kids, want.kids);
        cmp_field("status", got.code, want.code);
        cmp_field("token_total", got.total, want.total);
        cmp_field("open_left", got.left, want.left);
        cmp_field("last_of_run", got.last, want.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_q         = 9'(MAX_TOKENS);
            fail_count      = 0;
            records_checked = 0;
            clear_line();
            pending_tokens.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_record();
        end
        tokens_pending = pending_tokens.size();
    end

endmodule

### test/json_structure_tokenizer_core_tb.sv
// Testbench top for json_structure_tokenizer_core: clock, reset, JSON line stimulus,
// token_limit writes and verdict. Depends on jst_pkg and json_structure_tokenizer_checker.
`timescale 1ns / 1ps

module json_structure_tokenizer_core_tb;
    import jst_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;
    localparam int RAND_BYTES  = 100;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [8:0]         cfg_data;

    int   fail_count;
    int   tokens_pending;
    int   records_checked;
    int   cycles;
    int   bytes_sent;
    int   lines_sent;
    bit   calm;
    bit   stall_now;
    bit   stall_done;

    logic [7:0] line_buf[$];

    json_structure_tokenizer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    json_structure_tokenizer_checker tok_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .tokens_pending  (tokens_pending),
        .records_checked (records_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d records outstanding", cycles, tokens_pending);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random backpressure, one long hold-off on request
    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_now && !stall_done) begin
                stall_done = 1'b1;
                hold_left  = 79;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while (!calm && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // stop offering bytes until every predicted record has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_limit(logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_ws();
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0: line_buf.push_back(CH_SPACE);
                1: line_buf.push_back(CH_TAB);
                2: line_buf.push_back(CH_CR);
                default: line_buf.push_back(CH_LF);
            endcase
        end
    endtask

    task automatic add_string();
        int         n;
        logic [7:0] b;
        line_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 15)
                line_buf.push_back(CH_BSLASH);
            else if (b == CH_QUOTE || b == CH_BSLASH)
                b = 8'h61;
            line_buf.push_back(b);
        end
        line_buf.push_back(CH_QUOTE);
    endtask

    task automatic add_prim();
        string lead;
        string body;
        int    n;
        lead = "0123456789-tfn";
        body = "0123456789.eE+-truefalsn:{[\"";
        line_buf.push_back(lead[$urandom_range(0, lead.len() - 1)]);
        n = $urandom_range(0, 3);
        repeat (n)
            line_buf.push_back(body[$urandom_range(0, body.len() - 1)]);
    endtask

    task automatic add_value(int lvl);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (lvl < 3 && r < 25) begin
            line_buf.push_back(CH_LBRACE);
            add_ws();
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i > 0)
                    line_buf.push_back(CH_COMMA);
                add_ws();
                add_string();
                add_ws();
                line_buf.push_back(CH_COLON);
                add_ws();
                add_value(lvl + 1);
                add_ws();
            end
            line_buf.push_back(CH_RBRACE);
        end else if (lvl < 3 && r < 50) begin
            line_buf.push_back(CH_LBRACKET);
            add_ws();
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0)
                    line_buf.push_back(CH_COMMA);
                add_ws();
                add_value(lvl + 1);
                add_ws();
            end
            line_buf.push_back(CH_RBRACKET);
        end else if (r < 75) begin
            add_string();
        end else begin
            add_prim();
        end
    endtask

    // mostly well-formed lines; some corrupted, truncated or plain noise
    task automatic build_line();
        int r;
        int n;
        int k;
        line_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            n = $urandom_range(1, 12);
            repeat (n)
                line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_ws();
            add_value(0);
            if ($urandom_range(0, 3) == 0) begin
                line_buf.push_back(CH_SPACE);
                add_value(0);
            end
            add_ws();
            if (r < 18) begin
                n = $urandom_range(1, 2);
                repeat (n)
                    line_buf[$urandom_range(0, line_buf.size() - 1)] =
                        8'($urandom_range(0, 255));
            end else if (r < 26 && line_buf.size() > 1) begin
                k = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > k)
                    void'(line_buf.pop_back());
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        stall_now = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // short directed lines at the reset limit
        line_buf.delete();
        put_str("{\"a\":[1,x]}");
        send_line();
        // string left open at the end of line, its closing quote escaped
        line_buf.delete();
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(CH_QUOTE);
        send_line();
        // stray close, then a primitive cut by the end of line
        line_buf.delete();
        line_buf.push_back(CH_RBRACKET);
        line_buf.push_back(8'h00);
        send_line();
        line_buf.delete();
        put_str("[}");
        send_line();

        write_limit(9'd1);
        line_buf.delete();
        put_str("[1]");
        send_line();
        write_limit(9'd0);
        line_buf.delete();
        put_str("x ");
        send_line();
        write_limit(9'd511);

        // random lines with limit changes between them
        while (bytes_sent < RAND_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0, 1: write_limit(9'($urandom_range(1, 12)));
                    2: write_limit(9'(MAX_TOKENS));
                    default: write_limit(9'($urandom_range(0, 511)));
                endcase
            end
            calm = (lines_sent >= 10 && lines_sent < 13);
            build_line();
            send_line();
        end
        calm = 1'b0;

        write_limit(9'(MAX_TOKENS));
        // nesting exactly at the stack limit, closed by a primitive end,
        // while the receiver holds off long enough for the queue to fill
        stall_now = 1'b1;
        line_buf.delete();
        repeat (STACK_DEPTH) line_buf.push_back(CH_LBRACKET);
        line_buf.push_back(8'h37);
        repeat (STACK_DEPTH) line_buf.push_back(CH_RBRACKET);
        send_line();
        stall_now = 1'b0;
        // one level too deep, sent back to back
        calm = 1'b1;
        line_buf.delete();
        repeat (STACK_DEPTH + 1) line_buf.push_back(CH_LBRACKET);
        line_buf.push_back(CH_SPACE);
        send_line();
        calm = 1'b0;

        drain();
        $display("ran %0d lines, %0d bytes; %0d records checked", lines_sent, bytes_sent,
                 records_checked);
        $display("limits 0/1/256/511/random, full nesting, nesting overflow, output hold-off");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/jst_pkg.sv
rtl/jst_front.sv
rtl/jst_queue.sv
rtl/jst_back.sv
rtl/json_structure_tokenizer_core.sv
test/json_structure_tokenizer_checker.sv
test/json_structure_tokenizer_core_tb.sv
